>>> hdl/quad_row_span_generator_defines.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef QUAD_ROW_SPAN_GENERATOR_DEFINES_SVH
`define QUAD_ROW_SPAN_GENERATOR_DEFINES_SVH

// same-cycle implication
`define QRSG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QRSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/qrsg_pkg.sv
package qrsg_pkg;

  localparam int CW         = 13;
  localparam int ROW_W      = 10;
  localparam int SPAN_W     = 10;
  localparam int NUM_LINES  = 6;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 4;
  localparam int CORNER_IW  = 3;
  localparam int LINE_IW    = 3;
  localparam int FRAC       = 16;
  localparam int SW         = 30;
  localparam int MW         = 30;
  localparam int OW         = 44;
  localparam int NW         = 45;
  localparam int DVW        = NW + FRAC;
  localparam int QW         = 33;
  localparam int XW         = 21;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic signed [SW-1:0] slope;
    logic signed [OW-1:0] offset;
    logic [CW-1:0]        xc;
    logic [CW-1:0]        yc;
  } line_par_t;

  typedef struct packed {
    logic                 sloped;
    logic signed [XW-1:0] fst;
    logic signed [XW-1:0] fen;
    coord_t               xlo;
    coord_t               xhi;
    logic                 at_lo;
    logic                 at_hi;
    logic                 neg_c;
    logic                 neg_n;
  } line_side_t;

  typedef struct packed {
    logic                              row_ok;
    line_side_t [NUM_LINES-1:0]        side;
  } item_side_t;

  typedef struct packed {
    item_side_t                        side;
    logic [NUM_LINES-1:0][DVW-1:0]     dvd_c;
    logic [NUM_LINES-1:0][DVW-1:0]     dvd_n;
  } item_t;

  function automatic logic [1:0] pair_first(input logic [LINE_IW-1:0] k);
    logic [1:0] r;
    case (k) inside
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_second(input logic [LINE_IW-1:0] k);
    logic [1:0] r;
    case (k) inside
      3'd0:       r = 2'd1;
      3'd1, 3'd3: r = 2'd2;
      default:    r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/quad_row_span_generator.sv
// valid_o is registered; a row passes the row register, queue, divider stages, span register and output register
// throughput: one row per cycle while busy is low, set by the 33-stage pipelined crossing dividers
// a corner write starts a line recompute on one iterative divider,
// during which busy is high and cfg_ready_o is low
// async reset puts all corners at 0 with slopes and offsets cleared; results cannot be stalled
module quad_row_span_generator #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [qrsg_pkg::ROW_W-1:0]       row_i,
  output logic                             valid_o,
  output logic                             span_valid_o,
  output logic [qrsg_pkg::SPAN_W-1:0]      span_start_o,
  output logic [qrsg_pkg::SPAN_W-1:0]      span_end_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [qrsg_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [qrsg_pkg::CW-1:0]          cfg_data_i
);
  import qrsg_pkg::*;

`include "quad_row_span_generator_defines.svh"

  coord_t [NUM_REGS-1:0]      corners;
  line_par_t [NUM_LINES-1:0]  lines;
  logic                       setup_busy;
  logic                       push, full, empty, pop;
  item_t                      f_item, q_item;

  qrsg_setup u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (setup_busy),
    .corners_o  (corners),
    .lines_o    (lines)
  );

  qrsg_front #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .row_i       (row_i),
    .setup_busy_i(setup_busy),
    .corners_i   (corners),
    .lines_i     (lines),
    .full_i      (full),
    .push_o      (push),
    .item_o      (f_item)
  );

  qrsg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (q_item)
  );

  qrsg_back #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (q_item),
    .pop_o       (pop),
    .lines_i     (lines),
    .valid_o     (valid_o),
    .span_valid_o(span_valid_o),
    .span_start_o(span_start_o),
    .span_end_o  (span_end_o)
  );

  `QRSG_ASSERT_NEXT(a_cfg_busy, cfg_valid_i && cfg_ready_o && (cfg_index_i < REG_IDX_W'(NUM_REGS)), busy, "corner write did not hold off items")
  `QRSG_ASSERT_NOW(a_ready_busy, !cfg_ready_o, busy, "items accepted during recompute")
  `QRSG_ASSERT_NOW(a_span_strobe, span_valid_o, valid_o, "span valid without result strobe")

endmodule

>>> hdl/qrsg_setup.sv
module qrsg_setup (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  logic [qrsg_pkg::REG_IDX_W-1:0]               cfg_index_i,
  input  logic [qrsg_pkg::CW-1:0]                      cfg_data_i,
  output logic                                         busy_o,
  output qrsg_pkg::coord_t [qrsg_pkg::NUM_REGS-1:0]    corners_o,
  output qrsg_pkg::line_par_t [qrsg_pkg::NUM_LINES-1:0] lines_o
);
  import qrsg_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_DIVA  = 6'b000100,
    ST_DIVX  = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_STORE = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic [LINE_IW-1:0]              line_q, line_d;
  coord_t [NUM_REGS-1:0]           corner_q, corner_d;
  line_par_t [NUM_LINES-1:0]       lines_q, lines_d;
  logic [MW:0]                     div_rem_q, div_rem_d;
  logic [MW-1:0]                   div_num_q, div_num_d;
  logic [MW-1:0]                   div_quo_q, div_quo_d;
  logic [MW-1:0]                   div_den_q, div_den_d;
  logic [4:0]                      cnt_q, cnt_d;
  logic signed [SW-1:0]            a_q, a_d;
  logic                            neg_q, neg_d;
  logic [CW-1:0]                   xc_q, xc_d;
  logic signed [SW+CW-1:0]         prod_q, prod_d;

  logic [1:0]                      fi, si;
  coord_t                          xa, ya, xb, yb;
  logic signed [CW:0]              dx, dy, dx_abs, dy_abs;
  logic [MW:0]                     shifted, rem_n;
  logic                            ge;
  logic [MW-1:0]                   quo_n;
  logic signed [SW-1:0]            a_new;
  logic [SW-1:0]                   m_st;
  logic                            wr;

  assign fi = pair_first(line_q);
  assign si = pair_second(line_q);
  assign xa = corner_q[{fi, 1'b0}];
  assign ya = corner_q[{fi, 1'b1}];
  assign xb = corner_q[{si, 1'b0}];
  assign yb = corner_q[{si, 1'b1}];
  assign dx = (CW+1)'(xa) - (CW+1)'(xb);
  assign dy = (CW+1)'(ya) - (CW+1)'(yb);
  assign dx_abs = dx[CW] ? -dx : dx;
  assign dy_abs = dy[CW] ? -dy : dy;

  assign shifted = {div_rem_q[MW-1:0], div_num_q[MW-1]};
  assign ge      = shifted >= {1'b0, div_den_q};
  assign rem_n   = ge ? shifted - {1'b0, div_den_q} : shifted;
  assign quo_n   = {div_quo_q[MW-2:0], ge};
  assign a_new   = neg_q ? -$signed(quo_n) : $signed(quo_n);
  assign m_st    = a_q[SW-1] ? SW'(-a_q) : SW'(a_q);

  assign wr          = cfg_valid_i && cfg_ready_o && (cfg_index_i < REG_IDX_W'(NUM_REGS));
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign corners_o   = corner_q;
  assign lines_o     = lines_q;

  always_comb begin
    state_d   = state_q;
    line_d    = line_q;
    corner_d  = corner_q;
    lines_d   = lines_q;
    div_rem_d = div_rem_q;
    div_num_d = div_num_q;
    div_quo_d = div_quo_q;
    div_den_d = div_den_q;
    cnt_d     = cnt_q;
    a_d       = a_q;
    neg_d     = neg_q;
    xc_d      = xc_q;
    prod_d    = prod_q;
    unique case (state_q)
      ST_IDLE: begin
        if (wr) begin
          corner_d[cfg_index_i[CORNER_IW-1:0]] = cfg_data_i;
          line_d  = '0;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (dx != '0 && dy != '0) begin
          div_rem_d = '0;
          div_quo_d = '0;
          div_num_d = MW'({dy_abs[CW-1:0], {FRAC{1'b0}}});
          div_den_d = MW'(dx_abs[CW-1:0]);
          neg_d     = dx[CW] ^ dy[CW];
          cnt_d     = '0;
          state_d   = ST_DIVA;
        end else begin
          a_d     = '0;
          xc_d    = '0;
          state_d = ST_MUL;
        end
      end
      ST_DIVA: begin
        div_rem_d = rem_n;
        div_num_d = div_num_q << 1;
        div_quo_d = quo_n;
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'(MW-1)) begin
          a_d = a_new;
          if (quo_n == '0) begin
            xc_d    = '0;
            state_d = ST_MUL;
          end else begin
            div_rem_d = '0;
            div_quo_d = '0;
            div_num_d = MW'(1) << (FRAC-1);
            div_den_d = quo_n;
            cnt_d     = '0;
            state_d   = ST_DIVX;
          end
        end
      end
      ST_DIVX: begin
        div_rem_d = rem_n;
        div_num_d = div_num_q << 1;
        div_quo_d = quo_n;
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'(MW-1)) begin
          xc_d    = quo_n[CW-1:0];
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = a_q * xa;
        state_d = ST_STORE;
      end
      ST_STORE: begin
        lines_d[line_q].slope  = a_q;
        lines_d[line_q].offset = (OW'(ya) <<< FRAC) - OW'(prod_q);
        lines_d[line_q].xc     = xc_q;
        lines_d[line_q].yc     = m_st[FRAC+CW:FRAC+1];
        if (line_q == LINE_IW'(NUM_LINES-1)) begin
          state_d = ST_IDLE;
        end else begin
          line_d  = line_q + 1'b1;
          state_d = ST_SETUP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      line_q   <= '0;
      corner_q <= '0;
      lines_q  <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      line_q   <= line_d;
      corner_q <= corner_d;
      lines_q  <= lines_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_num_q <= div_num_d;
    div_quo_q <= div_quo_d;
    div_den_q <= div_den_d;
    a_q       <= a_d;
    neg_q     <= neg_d;
    xc_q      <= xc_d;
    prod_q    <= prod_d;
  end

endmodule

>>> hdl/qrsg_front.sv
module qrsg_front #(
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start,
  output logic                                          busy,
  input  logic [qrsg_pkg::ROW_W-1:0]                    row_i,
  input  logic                                          setup_busy_i,
  input  qrsg_pkg::coord_t [qrsg_pkg::NUM_REGS-1:0]     corners_i,
  input  qrsg_pkg::line_par_t [qrsg_pkg::NUM_LINES-1:0] lines_i,
  input  logic                                          full_i,
  output logic                                          push_o,
  output qrsg_pkg::item_t                               item_o
);
  import qrsg_pkg::*;

  logic               f_valid_q, f_valid_d;
  logic [ROW_W-1:0]   f_row_q, f_row_d;
  logic               accept;
  coord_t             y, y1;
  line_side_t [NUM_LINES-1:0]      side_w;
  logic [NUM_LINES-1:0][DVW-1:0]   dvd_c_w, dvd_n_w;

  assign busy      = setup_busy_i | (f_valid_q & full_i);
  assign accept    = start & ~busy;
  assign f_valid_d = accept | (f_valid_q & full_i);
  assign f_row_d   = accept ? row_i : f_row_q;
  assign push_o    = f_valid_q & ~full_i;

  assign y  = $signed({{(CW-ROW_W){1'b0}}, f_row_q});
  assign y1 = y + CW'(1);

  for (genvar k = 0; k < NUM_LINES; k++) begin : g_line
    coord_t                xa, ya, xb, yb, ylo, yhi, xlo, xhi;
    logic                  inr;
    line_side_t            ls;
    logic signed [NW-1:0]  ty_c, ty_n, num_c, num_n;
    logic [NW-1:0]         mag_c, mag_n;

    always_comb begin
      xa = corners_i[{pair_first(LINE_IW'(k)), 1'b0}];
      ya = corners_i[{pair_first(LINE_IW'(k)), 1'b1}];
      xb = corners_i[{pair_second(LINE_IW'(k)), 1'b0}];
      yb = corners_i[{pair_second(LINE_IW'(k)), 1'b1}];
      if (ya > yb) begin
        xlo = xb; ylo = yb; xhi = xa; yhi = ya;
      end else begin
        xlo = xa; ylo = ya; xhi = xb; yhi = yb;
      end
      inr  = (y >= ylo) && (y <= yhi);
      ty_c = NW'(y) - NW'($signed({1'b0, lines_i[k].yc}));
      ty_n = NW'(y1) - NW'($signed({1'b0, lines_i[k].yc}));
      num_c = (ty_c <<< FRAC) - NW'(lines_i[k].offset);
      num_n = (ty_n <<< FRAC) - NW'(lines_i[k].offset);
      mag_c = num_c[NW-1] ? NW'(-num_c) : NW'(num_c);
      mag_n = num_n[NW-1] ? NW'(-num_n) : NW'(num_n);
      ls.sloped = 1'b0;
      ls.fst    = {XW{1'b1}};
      ls.fen    = {XW{1'b1}};
      if (!inr) begin
        ls.sloped = 1'b0;
      end else if (ya == yb) begin
        ls.fst = (xa > xb) ? XW'(xb) : XW'(xa);
        ls.fen = (xa > xb) ? XW'(xa) : XW'(xb);
      end else if (xa == xb) begin
        ls.fst = XW'(xa);
        ls.fen = XW'(xa);
      end else if (lines_i[k].slope != '0) begin
        ls.sloped = 1'b1;
      end
      ls.xlo   = xlo;
      ls.xhi   = xhi;
      ls.at_lo = (y == ylo);
      ls.at_hi = (y == yhi);
      ls.neg_c = num_c[NW-1] ^ lines_i[k].slope[SW-1];
      ls.neg_n = num_n[NW-1] ^ lines_i[k].slope[SW-1];
    end

    assign side_w[k]  = ls;
    assign dvd_c_w[k] = {mag_c, {FRAC{1'b0}}};
    assign dvd_n_w[k] = {mag_n, {FRAC{1'b0}}};
  end

  assign item_o.side.row_ok = ({{(CW-ROW_W){1'b0}}, f_row_q} < CW'(SCREEN_HEIGHT));
  assign item_o.side.side   = side_w;
  assign item_o.dvd_c       = dvd_c_w;
  assign item_o.dvd_n       = dvd_n_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_row_q <= f_row_d;
  end

endmodule

>>> hdl/qrsg_queue.sv
module qrsg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qrsg_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output qrsg_pkg::item_t item_o
);
  import qrsg_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

>>> hdl/qrsg_div.sv
module qrsg_div (
  input  logic                      clk_i,
  input  logic [qrsg_pkg::DVW-1:0]  dvd_c_i,
  input  logic [qrsg_pkg::DVW-1:0]  dvd_n_i,
  input  logic [qrsg_pkg::MW-1:0]   den_i,
  output logic [qrsg_pkg::QW-1:0]   q_c_o,
  output logic [qrsg_pkg::QW-1:0]   q_n_o
);
  import qrsg_pkg::*;

  localparam int CMPW = MW + QW;

  logic [DVW-1:0] rc_q [QW];
  logic [DVW-1:0] rn_q [QW];
  logic [QW-1:0]  qc_q [QW];
  logic [QW-1:0]  qn_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [DVW-1:0]  rc_in, rn_in;
    logic [QW-1:0]   qc_in, qn_in;
    logic [CMPW-1:0] dsh, ec, en;
    logic            gc, gn;

    if (s == 0) begin : g_first
      assign rc_in = dvd_c_i;
      assign rn_in = dvd_n_i;
      assign qc_in = '0;
      assign qn_in = '0;
    end else begin : g_next
      assign rc_in = rc_q[s-1];
      assign rn_in = rn_q[s-1];
      assign qc_in = qc_q[s-1];
      assign qn_in = qn_q[s-1];
    end

    assign dsh = CMPW'(den_i) << B;
    assign ec  = CMPW'(rc_in);
    assign en  = CMPW'(rn_in);
    assign gc  = ec >= dsh;
    assign gn  = en >= dsh;

    always_ff @(posedge clk_i) begin
      rc_q[s] <= gc ? DVW'(ec - dsh) : rc_in;
      rn_q[s] <= gn ? DVW'(en - dsh) : rn_in;
      qc_q[s] <= qc_in | (QW'(gc) << B);
      qn_q[s] <= qn_in | (QW'(gn) << B);
    end
  end

  assign q_c_o = qc_q[QW-1];
  assign q_n_o = qn_q[QW-1];

endmodule

>>> hdl/qrsg_back.sv
module qrsg_back #(
  parameter int SCREEN_WIDTH = 1024
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          empty_i,
  input  qrsg_pkg::item_t                               item_i,
  output logic                                          pop_o,
  input  qrsg_pkg::line_par_t [qrsg_pkg::NUM_LINES-1:0] lines_i,
  output logic                                          valid_o,
  output logic                                          span_valid_o,
  output logic [qrsg_pkg::SPAN_W-1:0]                   span_start_o,
  output logic [qrsg_pkg::SPAN_W-1:0]                   span_end_o
);
  import qrsg_pkg::*;

  localparam logic signed [QW+1:0] HALF = (QW+2)'(1) << (FRAC-1);
  localparam logic signed [XW-1:0] WLIM = XW'(SCREEN_WIDTH);
  localparam logic signed [XW-1:0] WMAX = XW'(SCREEN_WIDTH - 1);

  function automatic logic signed [XW-1:0] cross_x(input logic [QW-1:0] q, input logic neg);
    logic signed [QW+1:0] v;
    logic signed [QW+1:0] w;
    logic [QW+1:0]        mag;
    logic [QW+1:0]        r;
    logic signed [XW-1:0] sz;
    v   = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    w   = v + HALF;
    mag = w[QW+1] ? (QW+2)'(-w) : (QW+2)'(w);
    r   = mag >> FRAC;
    sz  = XW'(r);
    return w[QW+1] ? -sz : sz;
  endfunction

  item_side_t            side_q [QW];
  logic [QW-1:0]         vld_q;
  logic [QW-1:0]         q_c [NUM_LINES];
  logic [QW-1:0]         q_n [NUM_LINES];
  logic signed [XW-1:0]  st_w [NUM_LINES];
  logic signed [XW-1:0]  en_w [NUM_LINES];
  logic signed [XW-1:0]  st_q [NUM_LINES];
  logic signed [XW-1:0]  en_q [NUM_LINES];
  logic                  e_vld_q, e_ok_q;

  logic                  found, valid;
  logic signed [XW-1:0]  smin, emax, sclip, eclip;
  logic                  out_vld_q, out_span_q;
  logic [SPAN_W-1:0]     out_st_q, out_en_q;

  assign pop_o = ~empty_i;

  for (genvar k = 0; k < NUM_LINES; k++) begin : g_line
    logic [MW-1:0]         den;
    line_side_t            s;
    logic signed [XW-1:0]  c, n, xcs, xlo, xhi, st, en;

    assign den = lines_i[k].slope[SW-1] ? MW'(-lines_i[k].slope) : MW'(lines_i[k].slope);

    qrsg_div u_div (
      .clk_i  (clk_i),
      .dvd_c_i(item_i.dvd_c[k]),
      .dvd_n_i(item_i.dvd_n[k]),
      .den_i  (den),
      .q_c_o  (q_c[k]),
      .q_n_o  (q_n[k])
    );

    always_comb begin
      s   = side_q[QW-1].side[k];
      c   = cross_x(q_c[k], s.neg_c);
      n   = cross_x(q_n[k], s.neg_n);
      xcs = XW'($signed({1'b0, lines_i[k].xc}));
      xlo = XW'(s.xlo);
      xhi = XW'(s.xhi);
      if (!s.sloped) begin
        st = s.fst;
        en = s.fen;
      end else if (c < n) begin
        st = s.at_lo ? xlo : c - xcs;
        en = s.at_hi ? xhi : n - xcs;
      end else if (c > n) begin
        st = s.at_hi ? xhi : n + XW'(1) + xcs;
        en = s.at_lo ? xlo : c + XW'(1) + xcs;
      end else begin
        st = c;
        en = c;
      end
    end

    assign st_w[k] = st;
    assign en_w[k] = en;
  end

  always_comb begin
    found = 1'b0;
    smin  = '0;
    emax  = {XW{1'b1}};
    for (int k = 0; k < NUM_LINES; k++) begin
      if (st_q[k] != {XW{1'b1}} && (!found || st_q[k] < smin)) begin
        smin  = st_q[k];
        found = 1'b1;
      end
      if (en_q[k] > emax) emax = en_q[k];
    end
    valid = e_ok_q && found && (smin < WLIM) && (emax >= 0) && (emax >= smin);
    sclip = (smin < 0) ? '0 : smin;
    eclip = (emax > WMAX) ? WMAX : emax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      e_vld_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      out_span_q <= 1'b0;
    end else begin
      vld_q      <= {vld_q[QW-2:0], ~empty_i};
      e_vld_q    <= vld_q[QW-1];
      out_vld_q  <= e_vld_q;
      out_span_q <= e_vld_q & valid;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= item_i.side;
    for (int i = 1; i < QW; i++) side_q[i] <= side_q[i-1];
    for (int k = 0; k < NUM_LINES; k++) begin
      st_q[k] <= st_w[k];
      en_q[k] <= en_w[k];
    end
    e_ok_q   <= side_q[QW-1].row_ok;
    out_st_q <= valid ? sclip[SPAN_W-1:0] : '0;
    out_en_q <= valid ? eclip[SPAN_W-1:0] : '0;
  end

  assign valid_o      = out_vld_q;
  assign span_valid_o = out_span_q;
  assign span_start_o = out_st_q;
  assign span_end_o   = out_en_q;

endmodule
